>>> hdl/nfha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfha_pkg: shared definitions of the next-fit handle allocator
// Field widths, action and status codes, and default parameter values.
// ----------------------------------------------------------------------------
package nfha_pkg;

  localparam int SLOT_COUNT_DEF   = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed widths of the word fields.
  localparam int ACTION_W  = 2;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam action_t ACT_ALLOCATE = 2'd0;
  localparam action_t ACT_RELEASE  = 2'd1;
  localparam action_t ACT_LOOKUP   = 2'd2;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;

endpackage : nfha_pkg
`default_nettype wire

>>> hdl/next_fit_handle_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_handle_allocator_unit: next-fit handle table
// Grants ids 1..SLOT_COUNT from a rotating pointer, frees them and looks up
// the payload stored with each id.
// ----------------------------------------------------------------------------
// Allocate and release write their result into the output register on
// acceptance; lookup first waits in the read state for the registered read
// data of the payload memory. The used marks live in flip-flops cleared by
// reset, and the next free id is found in the accepting cycle by a rotated
// priority search over them, so no clearing pass follows reset. The output
// register lets a new word be taken in the cycle the pending result is taken.
// A full pool answers status full; releasing or looking up a free or
// out-of-range id answers status not present.
module next_fit_handle_allocator_unit #(
  parameter int SLOT_COUNT   = nfha_pkg::SLOT_COUNT_DEF,
  parameter int PAYLOAD_BITS = nfha_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [nfha_pkg::ACTION_W-1:0]      in_action,
  input  wire logic [$clog2(SLOT_COUNT+1)-1:0]    in_slot,
  input  wire logic [nfha_pkg::PAYLOAD_W-1:0]     in_payload,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [$clog2(SLOT_COUNT+1)-1:0]    out_slot_id,
  output logic      [nfha_pkg::PAYLOAD_W-1:0]     out_found_payload,
  output logic      [nfha_pkg::STATUS_W-1:0]      out_status
);

  localparam int ID_W   = $clog2(SLOT_COUNT + 1);
  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int KEEP_W = (PAYLOAD_BITS < nfha_pkg::PAYLOAD_W) ? PAYLOAD_BITS
                                                                : nfha_pkg::PAYLOAD_W;
  localparam logic [ID_W-1:0]  SLOT_MAX = ID_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                         state_r, state_nxt;
  logic [SLOT_COUNT-1:0]          used_r, used_nxt;
  logic [ID_W-1:0]                next_cand_r, next_cand_nxt;
  logic                           hit_r, hit_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]                out_slot_id_r, out_slot_id_nxt;
  logic [nfha_pkg::PAYLOAD_W-1:0] out_found_payload_r, out_found_payload_nxt;
  nfha_pkg::status_t              out_status_r, out_status_nxt;

  logic                  in_fire;
  logic                  out_fire;
  logic [ID_W-1:0]       slot_m1;
  logic [IDX_W-1:0]      slot_idx;
  logic                  slot_used;
  logic [ID_W-1:0]       cand;
  logic [ID_W-1:0]       cand_m1;
  logic [IDX_W-1:0]      cand_idx;
  logic                  hit_hi, hit_lo;
  logic [IDX_W-1:0]      idx_hi, idx_lo;
  logic                  grant_ok;
  logic [IDX_W-1:0]      grant_idx;
  logic                  mem_we;
  logic [KEEP_W-1:0]     mem_rdata;

  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;

  assign slot_m1   = in_slot - ID_W'(1);
  assign slot_idx  = slot_m1[IDX_W-1:0];
  assign slot_used = (in_slot != '0) && (in_slot <= SLOT_MAX) && used_r[slot_idx];

  // The pointer always holds a valid id, but fall back to id 1 if it does not.
  assign cand     = ((next_cand_r != '0) && (next_cand_r <= SLOT_MAX)) ? next_cand_r
                                                                     : ID_W'(1);
  assign cand_m1  = cand - ID_W'(1);
  assign cand_idx = cand_m1[IDX_W-1:0];

  // Rotated priority search: lowest free entry at or above the pointer,
  // otherwise the lowest free entry overall.
  always_comb begin
    hit_hi = 1'b0;
    hit_lo = 1'b0;
    idx_hi = '0;
    idx_lo = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        hit_lo = 1'b1;
        idx_lo = IDX_W'(i);
        if (IDX_W'(i) >= cand_idx) begin
          hit_hi = 1'b1;
          idx_hi = IDX_W'(i);
        end
      end
    end
  end

  assign grant_ok  = hit_lo;
  assign grant_idx = hit_hi ? idx_hi : idx_lo;
  assign mem_we    = in_fire && (in_action == nfha_pkg::ACT_ALLOCATE) && grant_ok;

  nfha_ram #(
    .WIDTH (KEEP_W),
    .DEPTH (SLOT_COUNT)
  ) u_payload_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (grant_idx),
    .wdata (in_payload[KEEP_W-1:0]),
    .raddr (slot_idx),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt             = state_r;
    used_nxt              = used_r;
    next_cand_nxt         = next_cand_r;
    hit_nxt               = hit_r;
    out_valid_nxt         = out_valid_r && !out_fire;
    out_slot_id_nxt       = out_slot_id_r;
    out_found_payload_nxt = out_found_payload_r;
    out_status_nxt        = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_slot_id_nxt       = '0;
          out_found_payload_nxt = '0;
          out_status_nxt        = nfha_pkg::ST_OK;
          out_valid_nxt         = 1'b1;
          unique case (in_action)
            nfha_pkg::ACT_ALLOCATE: begin
              if (grant_ok) begin
                used_nxt[grant_idx] = 1'b1;
                out_slot_id_nxt     = ID_W'(grant_idx) + ID_W'(1);
                next_cand_nxt       = (grant_idx == IDX_LAST) ? ID_W'(1)
                                                              : ID_W'(grant_idx) + ID_W'(2);
              end else begin
                out_status_nxt = nfha_pkg::ST_FULL;
              end
            end
            nfha_pkg::ACT_RELEASE: begin
              if (slot_used) begin
                used_nxt[slot_idx] = 1'b0;
              end else begin
                out_status_nxt = nfha_pkg::ST_ABSENT;
              end
            end
            nfha_pkg::ACT_LOOKUP: begin
              // The result waits in the read state for the registered payload memory read.
              hit_nxt       = slot_used;
              out_valid_nxt = 1'b0;
              state_nxt     = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt         = 1'b1;
        out_slot_id_nxt       = '0;
        out_found_payload_nxt = hit_r ? nfha_pkg::PAYLOAD_W'(mem_rdata) : '0;
        out_status_nxt        = hit_r ? nfha_pkg::ST_OK : nfha_pkg::ST_ABSENT;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      next_cand_r <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      next_cand_r <= next_cand_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hit_r               <= hit_nxt;
    out_slot_id_r       <= out_slot_id_nxt;
    out_found_payload_r <= out_found_payload_nxt;
    out_status_r        <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_slot_id       = out_slot_id_r;
  assign out_found_payload = out_found_payload_r;
  assign out_status        = out_status_r;

  // A lookup in flight always finds the output register empty.
  a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> !out_valid_r)
    else $error("lookup completes while the output register is occupied");

  // A granted id is marked used in the next cycle.
  a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> used_r[$past(grant_idx)])
    else $error("granted id not marked used");

  // The rotating pointer stays a valid id.
  a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_cand_r != '0 && next_cand_r <= SLOT_MAX)
    else $error("next candidate out of range");

endmodule : next_fit_handle_allocator_unit
`default_nettype wire

>>> hdl/nfha_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfha_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nfha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : nfha_ram
`default_nettype wire

>>> tb/sv/tb_next_fit_handle_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_next_fit_handle_allocator_unit: self-checking bench of the handle table
// Drives allocate, release and lookup words with random gaps and output
// stalls. A scoreboard keeps its own copy of the used marks, the stored
// payloads and the next-fit pointer, predicts every result and compares it
// in order with what the block returns.
// ----------------------------------------------------------------------------
module tb_next_fit_handle_allocator_unit;

  localparam int SLOT_COUNT   = nfha_pkg::SLOT_COUNT_DEF;
  localparam int PAYLOAD_BITS = nfha_pkg::PAYLOAD_BITS_DEF;
  localparam int PAYLOAD_W    = nfha_pkg::PAYLOAD_W;
  localparam int SLOT_W       = $clog2(SLOT_COUNT + 1);
  localparam int RANDOM_WORDS = 1700;
  localparam int CALM_WORDS   = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam nfha_pkg::action_t ACT_NOOP = 2'd3;
  // Only the low PAYLOAD_BITS bits of a payload are stored.
  localparam logic [PAYLOAD_W-1:0] KEEP_MASK =
    PAYLOAD_W'((65'(1) << PAYLOAD_BITS) - 65'(1));

  typedef struct {
    logic [SLOT_W-1:0]    slot_id;
    logic [PAYLOAD_W-1:0] found_payload;
    nfha_pkg::status_t    status;
  } handle_result_t;

  class handle_table_scoreboard;
    bit                   used_mark[1:SLOT_COUNT];
    logic [PAYLOAD_W-1:0] stash[1:SLOT_COUNT];
    int unsigned          next_id;
    handle_result_t       awaited[$];
    int                   errors;

    function new();
      foreach (used_mark[i]) used_mark[i] = 1'b0;
      next_id = 1;
      errors  = 0;
    endfunction

    function bit holds(logic [SLOT_W-1:0] id);
      return id >= 1 && id <= SLOT_COUNT && used_mark[id];
    endfunction

    // Works out the result of one accepted word and updates the table copy.
    function void note_request(nfha_pkg::action_t act, logic [SLOT_W-1:0] id,
                               logic [PAYLOAD_W-1:0] data);
      handle_result_t r;
      int unsigned    cand;
      bit             got;
      r.slot_id       = '0;
      r.found_payload = '0;
      r.status        = nfha_pkg::ST_OK;
      got             = 1'b0;
      cand            = (next_id >= 1 && next_id <= SLOT_COUNT) ? next_id : 1;
      case (act)
        nfha_pkg::ACT_ALLOCATE: begin
          for (int n = 0; n < SLOT_COUNT; n++) begin
            if (!used_mark[cand]) begin
              got = 1'b1;
              break;
            end
            cand = (cand >= SLOT_COUNT) ? 1 : cand + 1;
          end
          if (got) begin
            used_mark[cand] = 1'b1;
            stash[cand]     = data & KEEP_MASK;
            next_id         = (cand >= SLOT_COUNT) ? 1 : cand + 1;
            r.slot_id       = cand[SLOT_W-1:0];
          end else begin
            r.status = nfha_pkg::ST_FULL;
          end
        end
        nfha_pkg::ACT_RELEASE: begin
          if (holds(id)) used_mark[id] = 1'b0;
          else r.status = nfha_pkg::ST_ABSENT;
        end
        nfha_pkg::ACT_LOOKUP: begin
          if (holds(id)) r.found_payload = stash[id];
          else r.status = nfha_pkg::ST_ABSENT;
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic [SLOT_W-1:0] id, logic [PAYLOAD_W-1:0] data,
                      nfha_pkg::status_t st);
      handle_result_t e;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected word id=%0d payload=%h status=%0d",
                                  id, data, st));
        return;
      end
      e = awaited.pop_front();
      if (id !== e.slot_id)
        report_mismatch($sformatf("slot_id %0d, want %0d", id, e.slot_id));
      if (data !== e.found_payload)
        report_mismatch($sformatf("found_payload %h, want %h", data,
                                  e.found_payload));
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", st, e.status));
    endtask
  endclass

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_valid   = 1'b0;
  logic [nfha_pkg::ACTION_W-1:0] in_action  = '0;
  logic [SLOT_W-1:0]             in_slot    = '0;
  logic [PAYLOAD_W-1:0]          in_payload = '0;
  logic                          out_stall  = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic [SLOT_W-1:0]             out_slot_id;
  logic [PAYLOAD_W-1:0]          out_found_payload;
  logic [nfha_pkg::STATUS_W-1:0] out_status;

  bit                     calm_tail = 1'b0;
  int unsigned            cycles    = 0;
  handle_table_scoreboard sb        = new();

  next_fit_handle_allocator_unit #(
    .SLOT_COUNT  (SLOT_COUNT),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_slot          (in_slot),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot_id      (out_slot_id),
    .out_found_payload(out_found_payload),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Both handshakes are sampled with the values that held before this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_action, in_slot, in_payload);
      if (out_valid && !out_stall) sb.check_result(out_slot_id, out_found_payload,
                                                   out_status);
    end
  end

  // The result side alternates stall bursts with free stretches.
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 30);
        out_stall <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Holds one word until it is taken; a gap first drops valid for a while.
  task automatic send_word(nfha_pkg::action_t act, logic [SLOT_W-1:0] id,
                           logic [PAYLOAD_W-1:0] data, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_slot    <= id;
    in_payload <= data;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [SLOT_W-1:0] pick_slot();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 12) return SLOT_W'($urandom_range(SLOT_COUNT + 1, (1 << SLOT_W) - 1));
    return SLOT_W'($urandom_range(1, SLOT_COUNT));
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int                gap;
    int unsigned       roll;
    int unsigned       mode;
    nfha_pkg::action_t act;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: empty table, both payload extremes, absent and
    // out-of-range ids, and the unused action code.
    send_word(nfha_pkg::ACT_LOOKUP,   7'd0,   32'h0,         0);
    send_word(nfha_pkg::ACT_RELEASE,  7'd1,   32'h0,         0);
    send_word(nfha_pkg::ACT_LOOKUP,   7'd64,  32'h0,         0);
    send_word(nfha_pkg::ACT_ALLOCATE, 7'd0,   32'h0000_0000, 0);
    send_word(nfha_pkg::ACT_ALLOCATE, 7'd0,   32'hFFFF_FFFF, 0);
    send_word(nfha_pkg::ACT_ALLOCATE, 7'd127, 32'hA5A5_5A5A, 2);
    send_word(nfha_pkg::ACT_LOOKUP,   7'd1,   32'hFFFF_FFFF, 0);
    send_word(nfha_pkg::ACT_LOOKUP,   7'd2,   32'h0,         0);
    send_word(nfha_pkg::ACT_LOOKUP,   7'd3,   32'h0,         1);
    send_word(nfha_pkg::ACT_RELEASE,  7'd1,   32'h0,         0);
    send_word(nfha_pkg::ACT_RELEASE,  7'd1,   32'h0,         0);
    send_word(nfha_pkg::ACT_LOOKUP,   7'd1,   32'h0,         0);
    send_word(ACT_NOOP,               7'd2,   32'hFFFF_FFFF, 0);
    send_word(nfha_pkg::ACT_RELEASE,  7'd0,   32'h0,         0);
    send_word(nfha_pkg::ACT_RELEASE,  7'd127, 32'h0,         0);
    send_word(nfha_pkg::ACT_LOOKUP,   7'd65,  32'h0,         3);
    send_word(nfha_pkg::ACT_LOOKUP,   7'd127, 32'h0,         0);
    send_word(nfha_pkg::ACT_ALLOCATE, 7'd64,  32'h8000_0001, 0);
    send_word(nfha_pkg::ACT_LOOKUP,   7'd4,   32'h0,         0);
    send_word(nfha_pkg::ACT_RELEASE,  7'd2,   32'h0,         0);
    send_word(nfha_pkg::ACT_LOOKUP,   7'd2,   32'h0,         0);

    // Random part in blocks that fill, drain or mix the table, so that the
    // pool runs full and the pointer wraps many times.
    mode = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) mode = (i < 300) ? 0 : $urandom_range(0, 2);
      if (i == RANDOM_WORDS - CALM_WORDS) calm_tail = 1'b1;
      roll = $urandom_range(0, 99);
      case (mode)
        0:       act = (roll < 70) ? nfha_pkg::ACT_ALLOCATE :
                       (roll < 80) ? nfha_pkg::ACT_RELEASE :
                       (roll < 98) ? nfha_pkg::ACT_LOOKUP : ACT_NOOP;
        1:       act = (roll < 15) ? nfha_pkg::ACT_ALLOCATE :
                       (roll < 75) ? nfha_pkg::ACT_RELEASE :
                       (roll < 98) ? nfha_pkg::ACT_LOOKUP : ACT_NOOP;
        default: act = (roll < 40) ? nfha_pkg::ACT_ALLOCATE :
                       (roll < 70) ? nfha_pkg::ACT_RELEASE :
                       (roll < 98) ? nfha_pkg::ACT_LOOKUP : ACT_NOOP;
      endcase
      gap = (!calm_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      send_word(act, pick_slot(), pick_payload(), gap);
    end
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
